/* sv/ble_advert_device_matcher_assert.svh */
// Assertion macros shared by the advertisement matcher modules.
// No dependencies; take in with an include in modules that check themselves.
`ifndef BLE_ADVERT_DEVICE_MATCHER_ASSERT_SVH
`define BLE_ADVERT_DEVICE_MATCHER_ASSERT_SVH

// Check that a condition holds in the same cycle as its trigger.
`define BLEADM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("matcher check failed");

// Check that a condition holds in the cycle after its trigger.
`define BLEADM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("matcher check failed");

`endif

/* sv/bleadm_pkg.sv */
// Types, constants and device tables of the advertisement device matcher.
// No dependencies; used by every module of the block through scoped names.
package bleadm_pkg;

	localparam int MAX_SLOTS    = 16;
	localparam int MAX_MASK     = 32;
	localparam int ENTRIES_DEF  = 4;
	localparam int MASK_LEN_DEF = 32;
	localparam int USED_SLOTS   = 3;
	localparam int MAP_W        = 4;
	localparam int POS_W        = 6;

	localparam logic [POS_W-1:0] POS_MAX       = 6'd63;
	localparam logic [7:0]       WILDCARD      = 8'hFF;
	localparam logic [7:0]       NAME_END      = 8'h00;
	localparam logic [7:0]       THRESHOLD_RST = 8'hB0;

	// Shared name mask of the listed devices: "Flipper " then terminator
	localparam int FLIPPER_LEN = 9;
	localparam logic [7:0] FLIPPER_MASK [0:FLIPPER_LEN-1] = '{
		8'h46, 8'h6c, 8'h69, 8'h70, 8'h70, 8'h65, 8'h72, 8'h20, 8'h00
	};

	typedef struct packed {
		logic [23:0]       oui;
		logic signed [7:0] rssi;
		logic [7:0]        name_byte;
		logic              last;
	} in_word_t;

	typedef struct packed {
		logic             found;
		logic [MAP_W-1:0] matched_entries;
	} out_word_t;

	// Vendor prefix of each slot; unused slots read zero
	function automatic logic [23:0] oui_entry(input int e);
		logic [23:0] v;
		case (e)
			0:       v = 24'h80E126;
			1:       v = 24'h80E127;
			2:       v = 24'h0CFA22;
			default: v = 24'h000000;
		endcase
		return v;
	endfunction

	function automatic logic slot_used(input int e);
		return e < USED_SLOTS;
	endfunction

	// Mask byte of a slot at a name position
	function automatic logic [7:0] mask_byte(input int e, input logic [POS_W-1:0] k);
		logic [7:0] v;
		v = NAME_END;
		if (e < USED_SLOTS && k < POS_W'(FLIPPER_LEN))
			v = FLIPPER_MASK[k[3:0]];
		return v;
	endfunction

	// Position of the first terminator, or the limit if none; constant use only
	function automatic logic [POS_W-1:0] mask_length(input int e, input int lim);
		logic [POS_W-1:0] len;
		logic             hit;
		len = POS_W'(lim);
		hit = 1'b0;
		for (int k = 0; k < lim; k++) begin
			if (!hit && mask_byte(e, POS_W'(k)) == NAME_END) begin
				len = POS_W'(k);
				hit = 1'b1;
			end
		end
		return len;
	endfunction

endpackage

/* sv/bleadm_core.sv */
// Per-entry mask tracking and final judgement of one advertisement.
// Depends on bleadm_pkg and the assertion macro header.
`include "ble_advert_device_matcher_assert.svh"

module bleadm_core #(
	parameter int ENTRIES  = bleadm_pkg::ENTRIES_DEF,
	parameter int MASK_LEN = bleadm_pkg::MASK_LEN_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  acc,
	input  bleadm_pkg::in_word_t  word,
	input  logic                  cfg_we,
	input  logic [7:0]            cfg_data,
	output logic                  res_valid,
	output bleadm_pkg::out_word_t res_word
);

	localparam int PW = bleadm_pkg::POS_W;

	logic signed [7:0] thr_q;
	logic [ENTRIES-1:0] alive_q;
	logic [PW-1:0]      pos_q;
	logic               ended_q;

	logic [ENTRIES-1:0] alive_n;
	logic [PW-1:0]      pos_n;
	logic               ended_n;
	logic               cmp_en;
	logic               rssi_ok;
	logic [ENTRIES-1:0] map;

	// Advance name position and end flag for this word
	always_comb begin
		pos_n   = pos_q;
		ended_n = ended_q;
		cmp_en  = 1'b0;
		if (!ended_q) begin
			if (word.name_byte == bleadm_pkg::NAME_END) begin
				ended_n = 1'b1;
			end else begin
				cmp_en = pos_q < PW'(MASK_LEN);
				if (pos_q < bleadm_pkg::POS_MAX)
					pos_n = pos_q + 1'b1;
			end
		end
	end

	assign rssi_ok = $signed(word.rssi) > thr_q;

	// Compare the byte against every mask in parallel and judge each entry
	for (genvar i = 0; i < ENTRIES; i++) begin : g_entry
		localparam logic [PW-1:0] LEN = bleadm_pkg::mask_length(i, MASK_LEN);
		logic [7:0] m;
		assign m = bleadm_pkg::mask_byte(i, pos_q);
		assign alive_n[i] = alive_q[i] && !(cmp_en && m != bleadm_pkg::NAME_END &&
			m != bleadm_pkg::WILDCARD && m != word.name_byte);
		assign map[i] = bleadm_pkg::slot_used(i) && alive_n[i] && rssi_ok &&
			bleadm_pkg::oui_entry(i) == word.oui && LEN <= pos_n;
	end

	// Hold the threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= bleadm_pkg::THRESHOLD_RST;
		end else if (cfg_we) begin
			thr_q <= cfg_data;
		end
	end

	// Update per-advertisement state; restart it after the last word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= '1;
			pos_q   <= '0;
			ended_q <= 1'b0;
		end else if (acc) begin
			if (word.last) begin
				alive_q <= '1;
				pos_q   <= '0;
				ended_q <= 1'b0;
			end else begin
				alive_q <= alive_n;
				pos_q   <= pos_n;
				ended_q <= ended_n;
			end
		end
	end

	// Result of the last word; extra map bits dropped, missing bits zero
	assign res_valid     = acc && word.last;
	assign res_word.found = |map;
	for (genvar j = 0; j < bleadm_pkg::MAP_W; j++) begin : g_map
		if (j < ENTRIES) begin : g_bit
			assign res_word.matched_entries[j] = map[j];
		end else begin : g_pad
			assign res_word.matched_entries[j] = 1'b0;
		end
	end

	`BLEADM_ASSERT_NEXT(a_restart, clk, arst_n, acc && word.last,
		pos_q == '0 && !ended_q && alive_q == '1)
	`BLEADM_ASSERT_NEXT(a_advance, clk, arst_n,
		acc && !word.last && !ended_q && word.name_byte != bleadm_pkg::NAME_END &&
		pos_q != bleadm_pkg::POS_MAX, pos_q == $past(pos_q) + 1'b1)

endmodule

/* sv/bleadm_obuf.sv */
// Two-deep result buffer: output register plus skid register.
// Depends on bleadm_pkg and the assertion macro header.
`include "ble_advert_device_matcher_assert.svh"

module bleadm_obuf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  res_valid,
	input  bleadm_pkg::out_word_t res_word,
	output logic                  full,
	output logic                  out_valid,
	input  logic                  out_stall,
	output bleadm_pkg::out_word_t out_word
);

	logic                  out_valid_q;
	logic                  skid_valid_q;
	bleadm_pkg::out_word_t out_word_q;
	bleadm_pkg::out_word_t skid_word_q;
	logic                  take;

	assign take = out_valid_q && !out_stall;

	// Control: refill from skid first, park a new word in skid when blocked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take)
				skid_valid_q <= 1'b0;
		end else if (res_valid) begin
			if (out_valid_q && !take)
				skid_valid_q <= 1'b1;
			else
				out_valid_q <= 1'b1;
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take)
				out_word_q <= skid_word_q;
		end else if (res_valid) begin
			if (out_valid_q && !take)
				skid_word_q <= res_word;
			else
				out_word_q <= res_word;
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	`BLEADM_ASSERT_NOW(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q)
	`BLEADM_ASSERT_NEXT(a_skid_drain, clk, arst_n, skid_valid_q && take,
		out_valid_q && !skid_valid_q)

endmodule

/* sv/ble_advert_device_matcher.sv */
// Top level of the advertisement device matcher.
// Depends on bleadm_pkg, bleadm_core and bleadm_obuf.
//
// Name bytes of one advertisement stream in one word per cycle on the adv
// channel, each with the advertiser OUI and signal strength; the word with
// last set closes the advertisement and yields exactly one result word with
// the found flag and the bitmap of matching table entries, registered.
// Every entry's mask byte compare runs in parallel in a single pass, so a
// word is taken each cycle; the two-deep result buffer lets input continue
// while a result waits, and input stalls only when both buffer slots hold
// unread results. The threshold is written on the cfg channel, always ready.
module ble_advert_device_matcher #(
	parameter int ENTRIES  = bleadm_pkg::ENTRIES_DEF,
	parameter int MASK_LEN = bleadm_pkg::MASK_LEN_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv_valid,
	output logic                  adv_stall,
	input  bleadm_pkg::in_word_t  adv_word,
	output logic                  res_valid,
	input  logic                  res_stall,
	output bleadm_pkg::out_word_t res_word,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [7:0]            cfg_data
);

	logic                  acc;
	logic                  full;
	logic                  core_valid;
	bleadm_pkg::out_word_t core_word;

	assign adv_stall = full;
	assign acc       = adv_valid && !full;
	assign cfg_ready = 1'b1;

	bleadm_core #(
		.ENTRIES  (ENTRIES),
		.MASK_LEN (MASK_LEN)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.word      (adv_word),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.res_valid (core_valid),
		.res_word  (core_word)
	);

	bleadm_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (core_valid),
		.res_word  (core_word),
		.full      (full),
		.out_valid (res_valid),
		.out_stall (res_stall),
		.out_word  (res_word)
	);

endmodule
